// ===== design/nmt_pkg.sv =====
package nmt_pkg;

   // table geometry
   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // field widths
   localparam int FUNC_W = 3;
   localparam int KEY_W  = 8;
   localparam int LINE_W = 32;
   localparam int COL_W  = 16;

   // packed beat widths, padded to whole bytes
   localparam int REQ_BITS    = FUNC_W + KEY_W + LINE_W + COL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + LINE_W + COL_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // response beat bit positions
   localparam int RSP_LINE_LO = 1;
   localparam int RSP_LINE_HI = RSP_LINE_LO + LINE_W - 1;
   localparam int RSP_COL_LO  = RSP_LINE_HI + 1;
   localparam int RSP_COL_HI  = RSP_COL_LO + COL_W - 1;

   // special keys
   localparam logic [KEY_W-1:0] KEY_QUOTE    = 8'h27;
   localparam logic [KEY_W-1:0] KEY_BACKTICK = 8'h60;
   localparam logic [KEY_W-1:0] KEY_FREE     = 8'h00;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR_ALL   = 3'd0,
      FUNC_SET_NAMED   = 3'd1,
      FUNC_SET_CONTEXT = 3'd2,
      FUNC_LOOKUP      = 3'd3,
      FUNC_CLEAR_LINE  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   // command held steady while it walks the chain
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
   } cmd_type;

   // partial result handed from cell to cell
   typedef struct packed {
      logic              matched;
      logic              free_seen;
      slot_idx_type      free_idx;
      logic              hit;
      logic [LINE_W-1:0] hit_line;
      logic [COL_W-1:0]  hit_column;
   } acc_type;

   // deferred claim of a free slot
   typedef struct packed {
      logic         en;
      slot_idx_type idx;
   } commit_type;

   function automatic logic is_letter(input logic [KEY_W-1:0] k);
      return k inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

endpackage

// ===== design/nmt_cell.sv =====
module nmt_cell import nmt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  slot_idx_type cell_idx,
   input  cmd_type      cmd,
   input  commit_type   commit,
   input  logic         token_in,
   input  acc_type      acc_in,
   output logic         token_out,
   output acc_type      acc_out
);

   logic [KEY_W-1:0]  name_ff, name_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              token_ff;
   acc_type           acc_ff, acc_in_next;
   logic              match;

   assign match = (name_ff == cmd.key) && (cmd.key != KEY_FREE);

   // slot update and partial result for the passing command
   always_comb begin
      name_in     = name_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      acc_in_next = acc_in;
      if (token_in) begin
         case (cmd.func)
            FUNC_CLEAR_ALL: begin
               name_in = KEY_FREE;
            end
            FUNC_SET_NAMED: begin
               if (is_letter(cmd.key)) begin
                  if (match) begin
                     line_in             = cmd.line;
                     col_in              = cmd.column;
                     acc_in_next.matched = 1'b1;
                  end
                  if ((name_ff == KEY_FREE) && !acc_in.free_seen) begin
                     acc_in_next.free_seen = 1'b1;
                     acc_in_next.free_idx  = cell_idx;
                  end
               end
            end
            FUNC_LOOKUP: begin
               if (match && !acc_in.hit) begin
                  acc_in_next.hit        = 1'b1;
                  acc_in_next.hit_line   = line_ff;
                  acc_in_next.hit_column = col_ff;
               end
            end
            FUNC_CLEAR_LINE: begin
               if (line_ff == cmd.line) begin
                  name_in = KEY_FREE;
               end
            end
            default: ;
         endcase
      end
      // new name lands in the first free slot once no match was found
      if (commit.en && (commit.idx == cell_idx)) begin
         name_in = cmd.key;
         line_in = cmd.line;
         col_in  = cmd.column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff  <= KEY_FREE;
         token_ff <= 1'b0;
      end else begin
         name_ff  <= name_in;
         token_ff <= token_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      line_ff <= line_in;
      col_ff  <= col_in;
      if (token_in) begin
         acc_ff <= acc_in_next;
      end
   end

   assign token_out = token_ff;
   assign acc_out   = acc_ff;

endmodule

// ===== design/named_mark_table_core.sv =====
// An accepted req beat starts a token through start_ff and the row of NUM_SLOTS
// slot cell registers; the finish step then loads the response register once
// it is free. No new req beat is taken until that command has left the finish step.
// A new req beat is taken while an earlier response still waits on rsp_tready.
// Reset (synchronous, active high) frees every slot, drops the context mark
// and empties the response register.
module named_mark_table_core import nmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: func[2:0], key[10:3], line_ref[42:11], column[58:43], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: ok[0], out_line[32:1], out_column[48:33], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int RSP_PAD = RSP_TDATA_W - RSP_BITS;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic              start_ff;
   logic              req_beat;
   commit_type        commit;
   logic              ctx_valid_ff, ctx_valid_in;
   logic [LINE_W-1:0] ctx_line_ff, ctx_line_in;
   logic [COL_W-1:0]  ctx_col_ff, ctx_col_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [LINE_W-1:0] rsp_line_ff, rsp_line_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              token [NUM_SLOTS+1];
   acc_type           acc   [NUM_SLOTS+1];
   acc_type           fin;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   // row of slot cells; the token enters at cell 0
   assign token[0] = start_ff;
   assign acc[0]   = '0;
   assign fin      = acc[NUM_SLOTS];

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      nmt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (SLOT_W'(i)),
         .cmd       (cmd_ff),
         .commit    (commit),
         .token_in  (token[i]),
         .acc_in    (acc[i]),
         .token_out (token[i+1]),
         .acc_out   (acc[i+1])
      );
   end

   // sequencer and result formation
   always_comb begin
      logic [LINE_W-1:0] lk_line;
      logic [COL_W-1:0]  lk_col;
      state_in     = state_ff;
      commit       = '0;
      ctx_valid_in = ctx_valid_ff;
      ctx_line_in  = ctx_line_ff;
      ctx_col_in   = ctx_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_col_in   = rsp_col_ff;
      lk_line      = '0;
      lk_col       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (token[NUM_SLOTS]) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_line_in  = '0;
               rsp_col_in   = '0;
               case (cmd_ff.func)
                  FUNC_CLEAR_ALL: begin
                     ctx_valid_in = 1'b0;
                  end
                  FUNC_SET_NAMED: begin
                     if (is_letter(cmd_ff.key)) begin
                        rsp_ok_in  = fin.matched || fin.free_seen;
                        commit.en  = !fin.matched && fin.free_seen;
                        commit.idx = fin.free_idx;
                     end
                  end
                  FUNC_SET_CONTEXT: begin
                     ctx_valid_in = 1'b1;
                     ctx_line_in  = cmd_ff.line;
                     ctx_col_in   = cmd_ff.column;
                     rsp_ok_in    = 1'b1;
                  end
                  FUNC_LOOKUP: begin
                     if ((cmd_ff.key == KEY_QUOTE) || (cmd_ff.key == KEY_BACKTICK)) begin
                        if (ctx_valid_ff) begin
                           lk_line = ctx_line_ff;
                           lk_col  = ctx_col_ff;
                        end
                     end else if (fin.hit) begin
                        lk_line = fin.hit_line;
                        lk_col  = fin.hit_column;
                     end
                     if (lk_line != '0) begin
                        rsp_ok_in   = 1'b1;
                        rsp_line_in = lk_line;
                        rsp_col_in  = lk_col;
                     end
                  end
                  FUNC_CLEAR_LINE: begin
                     if (ctx_valid_ff && (ctx_line_ff == cmd_ff.line)) begin
                        ctx_valid_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         ctx_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= req_beat;
         ctx_valid_ff <= ctx_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         cmd_ff.func   <= req_tdata[FUNC_W-1:0];
         cmd_ff.key    <= req_tdata[FUNC_W +: KEY_W];
         cmd_ff.line   <= req_tdata[FUNC_W+KEY_W +: LINE_W];
         cmd_ff.column <= req_tdata[FUNC_W+KEY_W+LINE_W +: COL_W];
      end
      ctx_line_ff <= ctx_line_in;
      ctx_col_ff  <= ctx_col_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_col_ff, rsp_line_ff, rsp_ok_ff};

endmodule

// ===== design/nmt_checker.sv =====
module nmt_checker import nmt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // a beat without ok carries no position
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_COL_HI:RSP_LINE_LO] == '0)
      else $error("position returned without ok");

   // the walk through the cells keeps a response from rising in the cycle after a request beat
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared right after request");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind named_mark_table_core nmt_checker u_nmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
